### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block cipher RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// S-box tables, round transforms and shared types for the block cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int NumStages = 15;
    localparam int NumKeys   = 15;

    typedef enum logic
    {
        KX_IDLE,
        KX_EXPAND
    } kx_state_t;

    typedef enum logic
    {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } aes_op_t;

    typedef enum logic [2:0]
    {
        REG_KEY0 = 3'd0,
        REG_KEY1 = 3'd1,
        REG_KEY2 = 3'd2,
        REG_KEY3 = 3'd3,
        REG_MODE = 3'd4
    } reg_idx_t;

    typedef struct packed
    {
        logic    vld;
        aes_op_t op;
    } stage_ctl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SBOX_REV [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_subst(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Byte i of the state sits at bits 127-8i; column i/4, row i%4.
    function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0]   b;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (inv)
                begin
                    b = s[127 - 8 * (4 * ((c + 4 - r) % 4) + r) -: 8];
                    t[127 - 8 * (4 * c + r) -: 8] = SBOX_REV[b];
                end
                else
                begin
                    b = s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8];
                    t[127 - 8 * (4 * c + r) -: 8] = SBOX[b];
                end
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0]   a1, a2, a3;
        logic [7:0]   x [4];
        logic [7:0]   x2 [4];
        logic [7:0]   x4 [4];
        logic [7:0]   x8 [4];
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                x[k]  = s[127 - 8 * (4 * c + k) -: 8];
                x2[k] = xtime(x[k]);
                x4[k] = xtime(x2[k]);
                x8[k] = xtime(x4[k]);
            end
            for (int r = 0; r < 4; r++)
            begin
                a1 = x[(r + 1) % 4];
                a2 = x[(r + 2) % 4];
                a3 = x[(r + 3) % 4];
                if (inv)
                begin
                    // Coefficients 0e, 0b, 0d, 09 built from the doubled terms.
                    t[127 - 8 * (4 * c + r) -: 8] =
                        (x8[r] ^ x4[r] ^ x2[r]) ^
                        (x8[(r + 1) % 4] ^ x2[(r + 1) % 4] ^ a1) ^
                        (x8[(r + 2) % 4] ^ x4[(r + 2) % 4] ^ a2) ^
                        (x8[(r + 3) % 4] ^ a3);
                end
                else
                begin
                    t[127 - 8 * (4 * c + r) -: 8] =
                        x2[r] ^ (x2[(r + 1) % 4] ^ a1) ^ a2 ^ a3;
                end
            end
        end
        return t;
    endfunction

endpackage

### rtl/aes_round_stage.sv
// ----------------------------------------------------------------------------
// AES round stage
// One registered cipher round for encryption or decryption, or a pass-through.
// ----------------------------------------------------------------------------
module aes_round_stage
    import aes_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         is_final,
    input  logic         is_pass,
    input  stage_ctl_t   ctl_in,
    input  logic [127:0] data_in,
    input  logic [127:0] key_enc,
    input  logic [127:0] key_dec,
    output stage_ctl_t   ctl_out,
    output logic [127:0] data_out
);

    stage_ctl_t   ctl_reg;
    logic [127:0] data_reg;
    logic [127:0] data_next;
    logic [127:0] ss;
    logic [127:0] keyed;
    logic         dec;

    always_comb
    begin
        dec   = (ctl_in.op == OP_DECRYPT);
        ss    = sub_shift(data_in, dec);
        keyed = ss;
        if (is_pass)
        begin
            data_next = data_in;
        end
        else if (!dec)
        begin
            keyed     = is_final ? ss : mix_columns(ss, 1'b0);
            data_next = keyed ^ key_enc;
        end
        else
        begin
            // Decryption applies the round key before the inverse column mix.
            keyed     = ss ^ key_dec;
            data_next = is_final ? keyed : mix_columns(keyed, 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '{vld: 1'b0, op: OP_ENCRYPT};
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign data_out = data_reg;

endmodule

### rtl/aes_block_cipher.sv
// ----------------------------------------------------------------------------
// AES block cipher
// Pipelined AES-128/AES-256 encrypt and decrypt with an APB key port.
// ----------------------------------------------------------------------------
// Items enter on the s_axis group: tdata holds the block, tuser the opcode.
// Results leave on the m_axis group, one per item, in order.
// The user must write the key and key length over APB only while the block
// is idle; the block itself does not enforce this. The first item after reset
// or after a key or mode register write waits while the key schedule is
// expanded, one schedule word per cycle. Round keys then sit in registers
// for later items. The datapath is a chain of 15 registered stages, an
// initial key add and one round per stage, and a new item can enter every
// cycle while the chain is not frozen. AES-128 items pass the last four
// stages unchanged.
// Reset clears all valid bits and marks the schedule stale.
// When the receiver holds m_tready low with a result waiting, the whole chain
// freezes and s_tready drops; nothing is dropped or duplicated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aes_block_cipher
    import aes_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // block_high [63:0], block_low [127:64]
    input  logic         s_tuser,   // opcode [0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // result_high [63:0], result_low [127:64]
);

    logic [63:0]  key_reg [4];
    logic         mode_reg;
    logic         sched_valid_reg;
    logic         sched_valid_next;
    kx_state_t    state_reg;
    kx_state_t    state_next;
    logic [5:0]   cnt_reg;
    logic [5:0]   cnt_next;
    logic [7:0]   rcon_reg;
    logic [7:0]   rcon_next;
    logic [31:0]  win_reg [8];
    logic [127:0] rk_reg [NumKeys];

    logic         cfg_we;
    reg_idx_t     cfg_idx;
    logic         kx_start;
    logic         kx_step;
    logic [31:0]  kx_temp;
    logic [31:0]  kx_word;
    logic [5:0]   kx_last;
    logic [2:0]   kx_mask;

    logic         adv;
    stage_ctl_t   ctl [NumStages];
    logic [127:0] dat [NumStages];
    stage_ctl_t   ctl0_reg;
    logic [127:0] dat0_reg;
    logic [127:0] blk;

    // Register port.
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[5:3]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_KEY0: prdata = key_reg[0];
            REG_KEY1: prdata = key_reg[1];
            REG_KEY2: prdata = key_reg[2];
            REG_KEY3: prdata = key_reg[3];
            REG_MODE: prdata = {63'd0, mode_reg};
            default:  prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= 64'd0;
            end
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3:
                    key_reg[paddr[4:3]] <= pwdata;
                REG_MODE:
                    mode_reg <= pwdata[0];
                default:
                    mode_reg <= mode_reg;
            endcase
        end
    end

    // Key expansion: a sliding window of the last eight schedule words.
    assign kx_mask = mode_reg ? 3'd7 : 3'd3;
    assign kx_last = mode_reg ? 6'd59 : 6'd43;

    always_comb
    begin
        kx_temp = win_reg[7];
        if ((cnt_reg[2:0] & kx_mask) == 3'd0)
        begin
            kx_temp = sbox_subst({win_reg[7][23:0], win_reg[7][31:24]}) ^ {rcon_reg, 24'd0};
        end
        else if (mode_reg && cnt_reg[2:0] == 3'd4)
        begin
            kx_temp = sbox_subst(win_reg[7]);
        end
        kx_word = (mode_reg ? win_reg[0] : win_reg[4]) ^ kx_temp;
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        rcon_next        = rcon_reg;
        sched_valid_next = sched_valid_reg;
        kx_start         = 1'b0;
        kx_step          = 1'b0;
        unique case (state_reg)
            KX_IDLE:
            begin
                if (s_tvalid && !sched_valid_reg)
                begin
                    kx_start   = 1'b1;
                    state_next = KX_EXPAND;
                    cnt_next   = mode_reg ? 6'd8 : 6'd4;
                    rcon_next  = 8'h01;
                end
            end
            KX_EXPAND:
            begin
                kx_step  = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if ((cnt_reg[2:0] & kx_mask) == 3'd0)
                begin
                    rcon_next = xtime(rcon_reg);
                end
                if (cnt_reg == kx_last)
                begin
                    state_next       = KX_IDLE;
                    sched_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = KX_IDLE;
            end
        endcase
        if (cfg_we)
        begin
            sched_valid_next = (cfg_idx > REG_MODE) ? sched_valid_next : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= KX_IDLE;
            sched_valid_reg <= 1'b0;
            cnt_reg         <= 6'd0;
            rcon_reg        <= 8'h01;
        end
        else
        begin
            state_reg       <= state_next;
            sched_valid_reg <= sched_valid_next;
            cnt_reg         <= cnt_next;
            rcon_reg        <= rcon_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (kx_start)
        begin
            if (mode_reg)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    win_reg[2 * i]     <= key_reg[i][63:32];
                    win_reg[2 * i + 1] <= key_reg[i][31:0];
                end
            end
            else
            begin
                // AES-128 keeps its four key words in the newest half of the window.
                for (int i = 0; i < 2; i++)
                begin
                    win_reg[4 + 2 * i] <= key_reg[i][63:32];
                    win_reg[5 + 2 * i] <= key_reg[i][31:0];
                end
            end
            rk_reg[0] <= {key_reg[0], key_reg[1]};
            rk_reg[1] <= {key_reg[2], key_reg[3]};
        end
        else if (kx_step)
        begin
            for (int i = 0; i < 7; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[7] <= kx_word;
            for (int k = 0; k < NumKeys; k++)
            begin
                if (cnt_reg[5:2] == 4'(k))
                begin
                    rk_reg[k][127 - 32 * cnt_reg[1:0] -: 32] <= kx_word;
                end
            end
        end
    end

    // Datapath pipeline; a waiting result freezes every stage.
    assign adv      = !(ctl[NumStages - 1].vld && !m_tready);
    assign s_tready = sched_valid_reg && (state_reg == KX_IDLE) && adv;
    assign blk      = {s_tdata[63:0], s_tdata[127:64]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '{vld: 1'b0, op: OP_ENCRYPT};
        end
        else if (adv)
        begin
            ctl0_reg <= '{vld: s_tvalid && s_tready, op: aes_op_t'(s_tuser)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dat0_reg <= blk ^ (s_tuser ? (mode_reg ? rk_reg[14] : rk_reg[10]) : rk_reg[0]);
        end
    end

    assign ctl[0] = ctl0_reg;
    assign dat[0] = dat0_reg;

    for (genvar j = 1; j < NumStages; j++)
    begin : g_round
        logic [127:0] kdec;
        if (j <= 10)
        begin : g_k10
            assign kdec = mode_reg ? rk_reg[14 - j] : rk_reg[10 - j];
        end
        else
        begin : g_k14
            assign kdec = rk_reg[14 - j];
        end

        aes_round_stage u_stage
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .is_final (mode_reg ? (j == 14) : (j == 10)),
            .is_pass  (!mode_reg && (j > 10)),
            .ctl_in   (ctl[j - 1]),
            .data_in  (dat[j - 1]),
            .key_enc  (rk_reg[j]),
            .key_dec  (kdec),
            .ctl_out  (ctl[j]),
            .data_out (dat[j])
        );
    end

    assign m_tvalid = ctl[NumStages - 1].vld;
    assign m_tdata  = {dat[NumStages - 1][63:0], dat[NumStages - 1][127:64]};

    `AST_IMPLY(a_accept_needs_sched, clk, rst_n, s_tvalid && s_tready, sched_valid_reg)
    `AST_IMPLY(a_no_accept_expand, clk, rst_n, state_reg == KX_EXPAND, !s_tready)
    `AST_NEXT(a_cfg_clears_sched, clk, rst_n, cfg_we && cfg_idx <= REG_MODE, !sched_valid_reg)
    `AST_NEXT(a_stall_freezes, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

endmodule
